### hdl/jtr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the JSON text reformatter.
package jtr_pkg;

    localparam int MAX_OUT = 6;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);
    localparam int IDX_W   = $clog2(MAX_OUT);
    localparam int RUN_W   = 12;
    localparam int DEPTH_W = 16;

    localparam logic [7:0] REG_PRETTY_MODE  = 8'd0;
    localparam logic [7:0] REG_INDENT_BYTE  = 8'd1;
    localparam logic [7:0] REG_INDENT_WIDTH = 8'd2;
    localparam logic [7:0] REG_EOL_CRLF     = 8'd3;

    typedef enum logic [2:0] {
        LEX_BETWEEN,
        LEX_STRING,
        LEX_ESC,
        LEX_VALUE,
        LEX_LINE,
        LEX_BLOCK,
        LEX_BSTAR
    } lex_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_OPEN,
        KIND_CLOSE,
        KIND_COLON,
        KIND_COMMA,
        KIND_VALUE,
        KIND_LINE,
        KIND_BLOCK
    } kind_t;

    typedef enum logic [1:0] {
        OPEN_NONE,
        OPEN_BRACE,
        OPEN_BRACKET
    } open_t;

    typedef struct packed {
        lex_t               lexer_state;
        kind_t              prev_kind;
        logic               at_line_start;
        logic               eol_pending;
        open_t              open_pending;
        logic [DEPTH_W-1:0] nest_depth;
        logic               held_slash;
    } state_t;

    typedef struct packed {
        logic       pretty_mode;
        logic [7:0] indent_byte;
        logic [3:0] indent_width;
        logic       eol_crlf;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [RUN_W-1:0] run_length;
        logic             last_of_item;
        logic             text_done;
    } result_t;

    typedef result_t [MAX_OUT-1:0] result_list_t;

    localparam state_t STATE_RESET = '{
        lexer_state:   LEX_BETWEEN,
        prev_kind:     KIND_NONE,
        at_line_start: 1'b1,
        eol_pending:   1'b0,
        open_pending:  OPEN_NONE,
        nest_depth:    '0,
        held_slash:    1'b0
    };

    localparam cfg_t CFG_RESET = '{
        pretty_mode:  1'b1,
        indent_byte:  8'd32,
        indent_width: 4'd4,
        eol_crlf:     1'b0
    };

endpackage

### hdl/jtr_step.sv
`timescale 1ns / 1ps
// Per-byte lexer and layout logic: one source byte in, up to six results out.
module jtr_step #(
    parameter int INDENT_LEVEL_CAP = 256
) (
    input  jtr_pkg::state_t              st_in,
    input  jtr_pkg::cfg_t                cfg,
    input  logic [7:0]                   text_byte,
    input  logic                         is_end,
    output jtr_pkg::state_t              state_next,
    output jtr_pkg::result_list_t        res_list,
    output logic [jtr_pkg::CNT_W-1:0]    res_cnt
);

    localparam int LEVEL_W = $clog2(INDENT_LEVEL_CAP + 1);
    localparam int PROD_W  = LEVEL_W + 4;
    localparam int RUN_W   = jtr_pkg::RUN_W;
    localparam int CNT_W   = jtr_pkg::CNT_W;
    localparam int IDX_W   = jtr_pkg::IDX_W;
    localparam int DEPTH_W = jtr_pkg::DEPTH_W;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        jtr_pkg::state_t       st;
        logic [CNT_W-1:0]      cnt;
        jtr_pkg::result_list_t res;
    } work_t;

    // Indent runs: only the incoming depth and that depth minus one can be
    // in force when a line prefix is written within one byte.
    typedef struct packed {
        jtr_pkg::cfg_t      cfg;
        logic [RUN_W-1:0]   run_cur;
        logic [RUN_W-1:0]   run_dec;
        logic [DEPTH_W-1:0] depth0;
    } ctx_t;

    logic [DEPTH_W-1:0] depth_dec;
    logic [LEVEL_W-1:0] level_cur;
    logic [LEVEL_W-1:0] level_dec;
    logic [PROD_W-1:0]  prod_cur;
    logic [PROD_W-1:0]  prod_dec;
    ctx_t               ctx;
    work_t              w;

    function automatic logic [LEVEL_W-1:0] level_f(logic [DEPTH_W-1:0] d);
        if (d < DEPTH_W'(INDENT_LEVEL_CAP)) begin
            return d[LEVEL_W-1:0];
        end
        return LEVEL_W'(INDENT_LEVEL_CAP);
    endfunction

    function automatic logic is_space_f(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_punct_f(logic [7:0] c);
        return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACK) ||
               (c == CH_RBRACK) || (c == CH_COLON) || (c == CH_COMMA) || (c == CH_QUOTE);
    endfunction

    function automatic logic sep_kind_f(jtr_pkg::kind_t k);
        return (k == jtr_pkg::KIND_VALUE) || (k == jtr_pkg::KIND_CLOSE) ||
               (k == jtr_pkg::KIND_BLOCK);
    endfunction

    function automatic work_t put_f(work_t w_in, logic [7:0] b, logic [RUN_W-1:0] run,
                                    logic done);
        work_t r;
        r = w_in;
        // drop anything past the sixth result
        if (r.cnt < CNT_W'(jtr_pkg::MAX_OUT)) begin
            r.res[r.cnt[IDX_W-1:0]].out_byte     = b;
            r.res[r.cnt[IDX_W-1:0]].run_length   = run;
            r.res[r.cnt[IDX_W-1:0]].last_of_item = 1'b0;
            r.res[r.cnt[IDX_W-1:0]].text_done    = done;
            r.cnt = r.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic work_t prefix_f(work_t w_in, ctx_t cx);
        work_t            r;
        logic [RUN_W-1:0] run;
        r = w_in;
        if (r.st.eol_pending) begin
            if (cx.cfg.eol_crlf) begin
                r = put_f(r, CH_CR, RUN_W'(1), 1'b0);
            end
            r = put_f(r, CH_LF, RUN_W'(1), 1'b0);
            r.st.eol_pending = 1'b0;
        end
        if (r.st.at_line_start && cx.cfg.pretty_mode) begin
            run = (r.st.nest_depth == cx.depth0) ? cx.run_cur : cx.run_dec;
            if (run != '0) begin
                r = put_f(r, cx.cfg.indent_byte, run, 1'b0);
            end
        end
        r.st.at_line_start = 1'b0;
        return r;
    endfunction

    function automatic work_t emit_f(work_t w_in, ctx_t cx, logic [7:0] b);
        work_t r;
        r = prefix_f(w_in, cx);
        r = put_f(r, b, RUN_W'(1), 1'b0);
        return r;
    endfunction

    function automatic work_t newline_f(work_t w_in);
        work_t r;
        r = w_in;
        if (!r.st.at_line_start) begin
            r.st.eol_pending   = 1'b1;
            r.st.at_line_start = 1'b1;
        end
        return r;
    endfunction

    function automatic work_t settle_f(work_t w_in, ctx_t cx);
        work_t r;
        r = w_in;
        if ((r.st.open_pending != jtr_pkg::OPEN_NONE) && cx.cfg.pretty_mode) begin
            r = newline_f(r);
        end
        r.st.open_pending = jtr_pkg::OPEN_NONE;
        return r;
    endfunction

    function automatic work_t separate_f(work_t w_in, ctx_t cx);
        work_t r;
        r = w_in;
        if (sep_kind_f(r.st.prev_kind) && !r.st.at_line_start) begin
            r = emit_f(r, cx, CH_SPACE);
        end
        return r;
    endfunction

    function automatic work_t between_f(work_t w_in, ctx_t cx, logic [7:0] c);
        work_t r;
        logic  match;
        r = w_in;
        if (!is_space_f(c)) begin
            if ((c == CH_LBRACE) || (c == CH_LBRACK)) begin
                r = settle_f(r, cx);
                r = separate_f(r, cx);
                r = emit_f(r, cx, c);
                if (r.st.nest_depth != '1) begin
                    r.st.nest_depth = r.st.nest_depth + DEPTH_W'(1);
                end
                r.st.open_pending = (c == CH_LBRACE) ? jtr_pkg::OPEN_BRACE
                                                     : jtr_pkg::OPEN_BRACKET;
                r.st.prev_kind = jtr_pkg::KIND_OPEN;
            end else if ((c == CH_RBRACE) || (c == CH_RBRACK)) begin
                // an empty pair stays on one line
                match = ((c == CH_RBRACE) && (r.st.open_pending == jtr_pkg::OPEN_BRACE)) ||
                        ((c == CH_RBRACK) && (r.st.open_pending == jtr_pkg::OPEN_BRACKET));
                r.st.open_pending = jtr_pkg::OPEN_NONE;
                if (r.st.nest_depth != '0) begin
                    r.st.nest_depth = r.st.nest_depth - DEPTH_W'(1);
                end
                if (cx.cfg.pretty_mode && !match) begin
                    r = newline_f(r);
                end
                r = emit_f(r, cx, c);
                r.st.prev_kind = jtr_pkg::KIND_CLOSE;
            end else if (c == CH_COLON) begin
                r = settle_f(r, cx);
                r = emit_f(r, cx, CH_COLON);
                if (cx.cfg.pretty_mode) begin
                    r = emit_f(r, cx, CH_SPACE);
                end
                r.st.prev_kind = jtr_pkg::KIND_COLON;
            end else if (c == CH_COMMA) begin
                r = settle_f(r, cx);
                r = emit_f(r, cx, CH_COMMA);
                if (cx.cfg.pretty_mode) begin
                    r = newline_f(r);
                end
                r.st.prev_kind = jtr_pkg::KIND_COMMA;
            end else if (c == CH_QUOTE) begin
                r = settle_f(r, cx);
                r = separate_f(r, cx);
                r = emit_f(r, cx, c);
                r.st.lexer_state = jtr_pkg::LEX_STRING;
                r.st.prev_kind   = jtr_pkg::KIND_VALUE;
            end else if (c == CH_SLASH) begin
                // hold the slash when a separating space may be needed
                r = settle_f(r, cx);
                if (!sep_kind_f(r.st.prev_kind)) begin
                    r = emit_f(r, cx, CH_SLASH);
                end
                r.st.held_slash = 1'b1;
            end else begin
                r = settle_f(r, cx);
                r = separate_f(r, cx);
                r = emit_f(r, cx, c);
                r.st.lexer_state = jtr_pkg::LEX_VALUE;
                r.st.prev_kind   = jtr_pkg::KIND_VALUE;
            end
        end
        return r;
    endfunction

    function automatic work_t in_value_f(work_t w_in, ctx_t cx, logic [7:0] c);
        work_t r;
        r = w_in;
        if (is_space_f(c)) begin
            r.st.lexer_state = jtr_pkg::LEX_BETWEEN;
        end else if (c == CH_SLASH) begin
            r = emit_f(r, cx, CH_SLASH);
            r.st.held_slash = 1'b1;
        end else if (is_punct_f(c)) begin
            r.st.lexer_state = jtr_pkg::LEX_BETWEEN;
            r = between_f(r, cx, c);
        end else begin
            r = emit_f(r, cx, c);
        end
        return r;
    endfunction

    function automatic work_t resolve_f(work_t w_in, ctx_t cx, logic [7:0] c);
        work_t r;
        logic  unwritten;
        r = w_in;
        unwritten = (r.st.lexer_state == jtr_pkg::LEX_BETWEEN) && sep_kind_f(r.st.prev_kind);
        r.st.held_slash = 1'b0;
        if ((c == CH_SLASH) || (c == CH_STAR)) begin
            if (unwritten) begin
                r = emit_f(r, cx, CH_SLASH);
            end
            r = emit_f(r, cx, c);
            r.st.lexer_state = (c == CH_SLASH) ? jtr_pkg::LEX_LINE : jtr_pkg::LEX_BLOCK;
            r.st.prev_kind   = (c == CH_SLASH) ? jtr_pkg::KIND_LINE : jtr_pkg::KIND_BLOCK;
        end else begin
            if (unwritten) begin
                r = emit_f(r, cx, CH_SPACE);
                r = emit_f(r, cx, CH_SLASH);
            end
            r.st.lexer_state = jtr_pkg::LEX_VALUE;
            r.st.prev_kind   = jtr_pkg::KIND_VALUE;
            r = in_value_f(r, cx, c);
        end
        return r;
    endfunction

    assign depth_dec = (st_in.nest_depth == '0) ? '0 : st_in.nest_depth - DEPTH_W'(1);
    assign level_cur = level_f(st_in.nest_depth);
    assign level_dec = level_f(depth_dec);
    assign prod_cur  = PROD_W'(level_cur) * PROD_W'(cfg.indent_width);
    assign prod_dec  = PROD_W'(level_dec) * PROD_W'(cfg.indent_width);

    always_comb begin
        ctx.cfg     = cfg;
        ctx.run_cur = RUN_W'(prod_cur);
        ctx.run_dec = RUN_W'(prod_dec);
        ctx.depth0  = st_in.nest_depth;
    end

    always_comb begin
        w.st  = st_in;
        w.cnt = '0;
        w.res = '0;
        if (w.st.held_slash) begin
            w = resolve_f(w, ctx, text_byte);
        end else begin
            case (w.st.lexer_state)
                jtr_pkg::LEX_STRING: begin
                    w = emit_f(w, ctx, text_byte);
                    if (text_byte == CH_BSLASH) begin
                        w.st.lexer_state = jtr_pkg::LEX_ESC;
                    end else if (text_byte == CH_QUOTE) begin
                        w.st.lexer_state = jtr_pkg::LEX_BETWEEN;
                    end
                end
                jtr_pkg::LEX_ESC: begin
                    w = emit_f(w, ctx, text_byte);
                    w.st.lexer_state = jtr_pkg::LEX_STRING;
                end
                jtr_pkg::LEX_VALUE: begin
                    w = in_value_f(w, ctx, text_byte);
                end
                jtr_pkg::LEX_LINE: begin
                    if ((text_byte == CH_LF) || (text_byte == CH_CR)) begin
                        w = newline_f(w);
                        w.st.lexer_state = jtr_pkg::LEX_BETWEEN;
                    end else begin
                        w = emit_f(w, ctx, text_byte);
                    end
                end
                jtr_pkg::LEX_BLOCK: begin
                    w = emit_f(w, ctx, text_byte);
                    if (text_byte == CH_STAR) begin
                        w.st.lexer_state = jtr_pkg::LEX_BSTAR;
                    end
                end
                jtr_pkg::LEX_BSTAR: begin
                    w = emit_f(w, ctx, text_byte);
                    if (text_byte == CH_SLASH) begin
                        w.st.lexer_state = jtr_pkg::LEX_BETWEEN;
                    end else if (text_byte != CH_STAR) begin
                        w.st.lexer_state = jtr_pkg::LEX_BLOCK;
                    end
                end
                default: begin
                    w.st.lexer_state = jtr_pkg::LEX_BETWEEN;
                    w = between_f(w, ctx, text_byte);
                end
            endcase
        end

        if (is_end) begin
            // an undecided slash at end of text is a value
            if (w.st.held_slash) begin
                if ((w.st.lexer_state == jtr_pkg::LEX_BETWEEN) &&
                    sep_kind_f(w.st.prev_kind)) begin
                    w = emit_f(w, ctx, CH_SPACE);
                    w = emit_f(w, ctx, CH_SLASH);
                end
                w.st.held_slash = 1'b0;
                w.st.prev_kind  = jtr_pkg::KIND_VALUE;
            end
            if (w.cnt < CNT_W'(jtr_pkg::MAX_OUT)) begin
                w = put_f(w, 8'd0, '0, 1'b1);
            end else begin
                w.res[IDX_W'(jtr_pkg::MAX_OUT - 1)].text_done = 1'b1;
            end
            w.st = jtr_pkg::STATE_RESET;
        end

        if (w.cnt != '0) begin
            w.res[w.cnt[IDX_W-1:0] - IDX_W'(1)].last_of_item = 1'b1;
        end
    end

    assign state_next = w.st;
    assign res_list   = w.res;
    assign res_cnt    = w.cnt;

endmodule

### hdl/jtr_outbuf.sv
`timescale 1ns / 1ps
// Result buffer: holds the results of one byte and drains them one per transfer.
module jtr_outbuf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  jtr_pkg::result_list_t       load_list,
    input  logic [jtr_pkg::CNT_W-1:0]   load_cnt,
    output logic                        free,
    output logic                        m_valid,
    input  logic                        m_ready,
    output jtr_pkg::result_t            m_result
);

    localparam int CNT_W = jtr_pkg::CNT_W;
    localparam int IDX_W = jtr_pkg::IDX_W;

    jtr_pkg::result_list_t list_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      rd_reg;
    logic                  take;

    assign m_valid  = (rd_reg != cnt_reg);
    assign take     = m_valid && m_ready;
    // free when empty, or once the last held result leaves in this cycle
    assign free     = !m_valid || (take && ((rd_reg + CNT_W'(1)) == cnt_reg));
    assign m_result = list_reg[rd_reg[IDX_W-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else if (load) begin
            cnt_reg <= load_cnt;
            rd_reg  <= '0;
        end else if (take) begin
            rd_reg <= rd_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            list_reg <= load_list;
        end
    end

endmodule

### hdl/json_text_reformatter.sv
`timescale 1ns / 1ps
// JSON text reformatter top level: input register, lexer state, config, result buffer.
// A byte is captured in the input register; its results are loaded into the result buffer once it is free.
// Throughput: one byte per cycle while each byte yields at most one result and m_ready is
// high; a byte with N results holds the next byte until the single-result output port drains them.
// Reset (synchronous, active low) restores the lexer state, config and valid/count registers to defaults.
module json_text_reformatter #(
    parameter int INDENT_LEVEL_CAP = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_is_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [11:0] m_run_length,
    output logic        m_last_of_item,
    output logic        m_text_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic                        in_end_reg;
    jtr_pkg::state_t             state_reg;
    jtr_pkg::state_t             state_next;
    jtr_pkg::cfg_t               cfg_reg;
    jtr_pkg::result_list_t       res_list;
    logic [jtr_pkg::CNT_W-1:0]   res_cnt;
    logic                        buf_free;
    logic                        step_fire;
    jtr_pkg::result_t            m_result;

    assign step_fire = in_valid_reg && buf_free;
    assign s_ready   = !in_valid_reg || step_fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_end_reg  <= s_is_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jtr_pkg::STATE_RESET;
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= jtr_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                jtr_pkg::REG_PRETTY_MODE:  cfg_reg.pretty_mode  <= cfg_data[0];
                jtr_pkg::REG_INDENT_BYTE:  cfg_reg.indent_byte  <= cfg_data;
                jtr_pkg::REG_INDENT_WIDTH: cfg_reg.indent_width <= cfg_data[3:0];
                jtr_pkg::REG_EOL_CRLF:     cfg_reg.eol_crlf     <= cfg_data[0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    jtr_step #(
        .INDENT_LEVEL_CAP(INDENT_LEVEL_CAP)
    ) u_step (
        .st_in      (state_reg),
        .cfg        (cfg_reg),
        .text_byte  (in_byte_reg),
        .is_end     (in_end_reg),
        .state_next (state_next),
        .res_list   (res_list),
        .res_cnt    (res_cnt)
    );

    jtr_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step_fire),
        .load_list (res_list),
        .load_cnt  (res_cnt),
        .free      (buf_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    assign m_out_byte     = m_result.out_byte;
    assign m_run_length   = m_result.run_length;
    assign m_last_of_item = m_result.last_of_item;
    assign m_text_done    = m_result.text_done;

endmodule
